>>> rtl/acorr_pkg.sv
package acorr_pkg;

  // Fixed field widths of the channels and the configuration register
  localparam int SAMPLE_W = 16;
  localparam int LAG_W    = 11;
  localparam int PAIR_W   = 21;
  localparam int MEAN_W   = 32;
  localparam int RATIO_W  = 16;

  // Ratio quotient: one integer bit and fourteen fraction bits
  localparam int RATIO_STEPS = 15;

  // Reset value of the lag register
  localparam logic [LAG_W-1:0] LAG_RESET = LAG_W'(1);

  // Saturation codes of the Q2.14 ratio
  localparam logic signed [RATIO_W-1:0] RATIO_POS_SAT = 16'sh7FFF;
  localparam logic signed [RATIO_W-1:0] RATIO_NEG_SAT = 16'sh8000;

endpackage

>>> rtl/acorr_in_if.sv
interface acorr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [acorr_pkg::SAMPLE_W-1:0] sample;
  logic                                 last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

>>> rtl/acorr_out_if.sv
interface acorr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [acorr_pkg::PAIR_W-1:0]         pair_count;
  logic signed [acorr_pkg::MEAN_W-1:0]  mean_correlation;
  logic signed [acorr_pkg::RATIO_W-1:0] normalized_ratio;
  logic                                 too_short;

  modport source (output valid, output pair_count, output mean_correlation,
                  output normalized_ratio, output too_short, input ready);
  modport sink   (input valid, input pair_count, input mean_correlation,
                  input normalized_ratio, input too_short, output ready);
endinterface

>>> rtl/lagged_autocorrelation.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   sample (s16 Q1.15), last
// out_ch    out  valid/ready   pair_count, mean_correlation, normalized_ratio, too_short
// cfg       in   cfg_we        cfg_wdata (lag, 11 bits)
//
// A sample that is summed goes through the ring read, two passes through the one
// 16x16 multiplier and the power add; a sample outside the sums skips these passes.
// A last sample adds the close of series: a setup step, 32 + $clog2(MAX_SAMPLES+1) steps
// of the shared shift-subtract divider for the mean, RATIO_STEPS for the ratio, hand-over.
// Reset (rst_n low, synchronous) sets lag to 1 and clears the series; the ring
// needs no clearing. A result waiting on out_ch stalls only the next close of series.
module lagged_autocorrelation #(
  parameter int MAX_LAG     = 1024,
  parameter int MAX_SAMPLES = 1048576
) (
  input  logic                           clk,
  input  logic                           rst_n,
  acorr_in_if.sink                       in_ch,
  acorr_out_if.source                    out_ch,
  input  logic                           cfg_we,
  input  logic [acorr_pkg::LAG_W-1:0]    cfg_wdata
);

  localparam int RING_AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int LAG_EW  = $clog2(MAX_LAG + 1);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int ACC_W   = 32 + CNT_W;
  localparam int STEP_W  = $clog2(ACC_W + 1);
  localparam int SW      = acorr_pkg::SAMPLE_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_MUL1  = 10'b00_0000_0010,
    S_MUL2  = 10'b00_0000_0100,
    S_ACC   = 10'b00_0000_1000,
    S_PREP  = 10'b00_0001_0000,
    S_DIVM  = 10'b00_0010_0000,
    S_RINIT = 10'b00_0100_0000,
    S_DIVR  = 10'b00_1000_0000,
    S_RFIN  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t                          state_r;
  logic [acorr_pkg::LAG_W-1:0]     cfg_lag_r;
  logic [RING_AW-1:0]              ptr_r;
  logic [CNT_W-1:0]                samples_r;
  logic signed [ACC_W-1:0]         corr_r;
  logic [ACC_W-1:0]                pow_r;
  logic signed [SW-1:0]            x_r;
  logic signed [SW-1:0]            d_r;
  logic                            last_r;
  logic [LAG_EW-1:0]               lag_q_r;
  logic signed [31:0]              prod_r;
  logic [CNT_W-1:0]                pairs_r;
  logic [ACC_W:0]                  rem_r;
  logic [ACC_W-1:0]                quo_r;
  logic [ACC_W-1:0]                den_r;
  logic [STEP_W-1:0]               step_r;
  logic signed [acorr_pkg::MEAN_W-1:0]  mean_r;
  logic signed [acorr_pkg::RATIO_W-1:0] ratio_r;

  logic                            out_valid_r;
  logic [acorr_pkg::PAIR_W-1:0]    out_pair_r;
  logic signed [acorr_pkg::MEAN_W-1:0]  out_mean_r;
  logic signed [acorr_pkg::RATIO_W-1:0] out_ratio_r;
  logic                            out_short_r;

  // Delay ring
  logic signed [SW-1:0]            ring_mem [MAX_LAG];
  logic signed [SW-1:0]            ring_rdata_r;

  logic                            accept;
  logic [LAG_EW-1:0]               eff_lag;
  logic                            active;
  logic                            do_sum;
  logic [RING_AW-1:0]              rd_addr;
  logic [31:0]                     ptr_ext;
  logic [31:0]                     lag_ext;
  logic [31:0]                     rd_ext;
  logic signed [SW-1:0]            d_sel;
  logic signed [SW-1:0]            mul_a;
  logic signed [SW-1:0]            mul_b;
  logic signed [31:0]              prod_c;
  logic [31:0]                     seen_ext;
  logic [31:0]                     lagq_ext;
  logic [CNT_W-1:0]                pairs_c;
  logic                            corr_neg;
  logic [ACC_W-1:0]                abs_corr;
  logic [ACC_W+1:0]                rem_sh;
  logic [ACC_W+1:0]                diff;
  logic                            qbit;
  logic [ACC_W-1:0]                mean_full;
  logic [acorr_pkg::RATIO_W-1:0]   mag;
  logic                            ratio_sat;
  logic                            load_out;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = rst_n && (state_r == S_IDLE);

  // Clamp the lag to the ring depth
  always_comb begin
    if (32'(cfg_lag_r) > 32'(MAX_LAG)) begin
      eff_lag = LAG_EW'(MAX_LAG);
    end else begin
      eff_lag = LAG_EW'(cfg_lag_r);
    end
  end

  assign active = (32'(samples_r) != 32'(MAX_SAMPLES));
  assign do_sum = active && (32'(samples_r) >= 32'(eff_lag));

  // Delayed read address, modulo the ring depth
  assign ptr_ext = 32'(ptr_r);
  assign lag_ext = 32'(eff_lag);
  always_comb begin
    if (ptr_ext >= lag_ext) begin
      rd_ext = ptr_ext - lag_ext;
    end else begin
      rd_ext = ptr_ext + 32'(MAX_LAG) - lag_ext;
    end
  end
  assign rd_addr = RING_AW'(rd_ext);

  // Ring write at the pointer, registered read at the delayed address
  always_ff @(posedge clk) begin
    if (accept && active) begin
      ring_mem[ptr_r] <= in_ch.sample;
    end
    if (accept) begin
      ring_rdata_r <= ring_mem[rd_addr];
    end
  end

  // Shared multiplier: d*x first, then d*d
  assign d_sel = (lag_q_r == '0) ? x_r : ring_rdata_r;
  always_comb begin
    mul_a = d_r;
    mul_b = d_r;
    if (state_r == S_MUL1) begin
      mul_a = d_sel;
      mul_b = x_r;
    end
  end
  assign prod_c = mul_a * mul_b;

  // Pair count at close of series
  assign seen_ext = 32'(samples_r);
  assign lagq_ext = 32'(lag_q_r);
  assign pairs_c  = (seen_ext > lagq_ext) ? CNT_W'(seen_ext - lagq_ext) : '0;

  assign corr_neg = corr_r[ACC_W-1];
  assign abs_corr = corr_neg ? ACC_W'(-corr_r) : ACC_W'(corr_r);

  // Shared shift-subtract divider step
  assign rem_sh = {rem_r, quo_r[ACC_W-1]};
  assign diff   = rem_sh - {2'b00, den_r};
  assign qbit   = !diff[ACC_W+1];

  assign mean_full = corr_neg ? (~quo_r + ACC_W'(1)) : quo_r;
  assign mag       = {1'b0, quo_r[acorr_pkg::RATIO_STEPS-1:0]};
  assign ratio_sat = ({1'b0, abs_corr} >= {pow_r, 1'b0});
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lag_r <= acorr_pkg::LAG_RESET;
    end else if (cfg_we) begin
      cfg_lag_r <= cfg_wdata;
    end
  end

  // Sequencer and series state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ptr_r     <= '0;
      samples_r <= '0;
      corr_r    <= '0;
      pow_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r     <= in_ch.sample;
            last_r  <= in_ch.last;
            lag_q_r <= eff_lag;
            if (active) begin
              ptr_r     <= (32'(ptr_r) == 32'(MAX_LAG - 1)) ? '0 : ptr_r + RING_AW'(1);
              samples_r <= samples_r + CNT_W'(1);
            end
            if (do_sum) begin
              state_r <= S_MUL1;
            end else if (in_ch.last) begin
              state_r <= S_PREP;
            end
          end
        end
        S_MUL1: begin
          d_r     <= d_sel;
          prod_r  <= prod_c;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          corr_r  <= corr_r + {{(ACC_W-32){prod_r[31]}}, prod_r};
          prod_r  <= prod_c;
          state_r <= S_ACC;
        end
        S_ACC: begin
          pow_r   <= pow_r + {{(ACC_W-32){1'b0}}, prod_r};
          state_r <= last_r ? S_PREP : S_IDLE;
        end
        S_PREP: begin
          pairs_r <= pairs_c;
          if (pairs_c == '0) begin
            mean_r  <= '0;
            ratio_r <= '0;
            state_r <= S_DONE;
          end else begin
            rem_r   <= '0;
            quo_r   <= abs_corr;
            den_r   <= ACC_W'(pairs_c);
            step_r  <= '0;
            state_r <= S_DIVM;
          end
        end
        S_DIVM: begin
          rem_r  <= qbit ? diff[ACC_W:0] : rem_sh[ACC_W:0];
          quo_r  <= {quo_r[ACC_W-2:0], qbit};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(ACC_W - 1)) begin
            state_r <= S_RINIT;
          end
        end
        S_RINIT: begin
          mean_r <= mean_full[acorr_pkg::MEAN_W-1:0];
          if (pow_r == '0) begin
            ratio_r <= '0;
            state_r <= S_DONE;
          end else if (ratio_sat) begin
            ratio_r <= corr_neg ? acorr_pkg::RATIO_NEG_SAT : acorr_pkg::RATIO_POS_SAT;
            state_r <= S_DONE;
          end else begin
            // First step compares the whole magnitude, then shift in zeros
            rem_r   <= {2'b00, abs_corr[ACC_W-1:1]};
            quo_r   <= {abs_corr[0], {(ACC_W-1){1'b0}}};
            den_r   <= pow_r;
            step_r  <= '0;
            state_r <= S_DIVR;
          end
        end
        S_DIVR: begin
          rem_r  <= qbit ? diff[ACC_W:0] : rem_sh[ACC_W:0];
          quo_r  <= {quo_r[ACC_W-2:0], qbit};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(acorr_pkg::RATIO_STEPS - 1)) begin
            state_r <= S_RFIN;
          end
        end
        S_RFIN: begin
          ratio_r <= corr_neg ? -$signed(mag) : $signed(mag);
          state_r <= S_DONE;
        end
        S_DONE: begin
          // Hand the result over and clear the series
          if (load_out) begin
            ptr_r     <= '0;
            samples_r <= '0;
            corr_r    <= '0;
            pow_r     <= '0;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pair_r  <= acorr_pkg::PAIR_W'(pairs_r);
      out_mean_r  <= mean_r;
      out_ratio_r <= ratio_r;
      out_short_r <= (pairs_r == '0);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.pair_count       = out_pair_r;
  assign out_ch.mean_correlation = out_mean_r;
  assign out_ch.normalized_ratio = out_ratio_r;
  assign out_ch.too_short        = out_short_r;

endmodule
